// ----- sv/random_probe_id_allocator_assert.svh -----
// assertion macros for the random probe id allocator
// no dependencies; taken in by the top level
`ifndef RANDOM_PROBE_ID_ALLOCATOR_ASSERT_SVH
`define RANDOM_PROBE_ID_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define RPIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rpia assertion failed");
`define RPIA_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rpia assertion failed");
`else
`define RPIA_ASSERT(lbl, prop)
`define RPIA_ASSERT_NORST(lbl, prop)
`endif
`endif

// ----- sv/rpia_pkg.sv -----
// shared constants, codes and control types of the random probe id allocator
// no dependencies
package rpia_pkg;

  localparam int ID_W    = 13;
  localparam int ID_LOW  = 300;
  localparam int ID_HIGH = 5000;
  localparam int ID_SPAN = ID_HIGH - ID_LOW + 1;

  localparam logic [ID_W-1:0] ID_LOW_V  = ID_W'(ID_LOW);
  localparam logic [ID_W-1:0] ID_HIGH_V = ID_W'(ID_HIGH);
  localparam logic [ID_W-1:0] ID_SPAN_V = ID_W'(ID_SPAN);

  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = $clog2(ROW_W);
  localparam int ROWS      = (ID_SPAN + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);

  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

  // modulo by reciprocal multiply, one correction step
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / ID_SPAN;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD1_W     = LFSR_W + RECIP_W;
  localparam int Q_W         = PROD1_W - RECIP_SHIFT;
  localparam int PROD2_W     = Q_W + ID_W;
  localparam int REM_W       = ID_W + 1;

  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    RES_NONE_FREE,
    RES_ALLOC,
    RES_RELEASE
  } res_sel_e;

  typedef struct packed {
    logic     clr;
    logic     take_in;
    logic     step;
    logic     mul2;
    logic     probe_rd;
    logic     rel_rd;
    logic     map_wr;
    logic     map_bit;
    logic     out_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic full;
    logic bit_set;
    logic rel_hit;
  } dp_stat_t;

endpackage

// ----- sv/random_probe_id_allocator.sv -----
// top level of the random probe id allocator; depends on rpia_pkg, rpia_ctrl,
// rpia_dp and random_probe_id_allocator_assert.svh
//
// hands out ids 300..5000 from an in-use bitmap by random probing
// request channel: in_valid_i/in_ready_o with command_i (0 allocate,
// 1 release) and id_i; result channel: out_valid_o/out_ready_i with
// id_out_o and status_o (0 ok, 1 none free, 2 not allocated)
// seed channel: cfg_valid_i/cfg_ready_o with cfg_rng_seed_i, always ready,
// loads the probe lfsr at once (zero loads as one); write it only when idle
// one request in flight; the next is taken once the result is in the
// output register, even while that result still waits to be taken
// release: bitmap row read, then bit check and result load
// allocate: each probe draw runs an lfsr step with reciprocal
// multiply, back multiply, remainder and bitmap row read, bit check;
// a set bit draws again, a free one is marked and loaded as the result
// full map: no probe; a none free result is loaded from its own state
// reset: bitmap is cleared one 32-bit row per cycle, all 147 rows, with
// in_ready_o low; seed register returns to one
// a stalled receiver holds the result; a finished request then waits
`include "random_probe_id_allocator_assert.svh"
module random_probe_id_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpia_pkg::LFSR_W-1:0]    cfg_rng_seed_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [rpia_pkg::ID_W-1:0]      id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rpia_pkg::ID_W-1:0]      id_out_o,
  output logic [rpia_pkg::STAT_W-1:0]    status_o
);

  rpia_pkg::dp_cmd_t  cmd;
  rpia_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rpia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpia_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_rng_seed_i (cfg_rng_seed_i),
    .id_i           (id_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .id_out_o       (id_out_o),
    .status_o       (status_o)
  );

  `RPIA_ASSERT_NORST(a_no_req_while_clearing, cmd.clr |-> !in_ready_o)
  `RPIA_ASSERT(a_set_only_free_bit, (cmd.map_wr && cmd.map_bit) |-> !stat.bit_set)
  `RPIA_ASSERT(a_ok_id_in_range, (out_valid_o && status_o == rpia_pkg::ST_OK) |-> (id_out_o >= rpia_pkg::ID_LOW_V && id_out_o <= rpia_pkg::ID_HIGH_V))
  `RPIA_ASSERT(a_none_free_zero_id, (out_valid_o && status_o == rpia_pkg::ST_NONE_FREE) |-> (id_out_o == '0 && $past(stat.full)))

endmodule

// ----- sv/rpia_ctrl.sv -----
// controller state machine of the random probe id allocator
// depends on rpia_pkg
module rpia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rpia_pkg::dp_stat_t stat_i,
  output rpia_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_STEP    = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_MOD     = 4'd4;
  localparam logic [3:0] S_CHK     = 4'd5;
  localparam logic [3:0] S_REL_RD  = 4'd6;
  localparam logic [3:0] S_REL_CHK = 4'd7;
  localparam logic [3:0] S_FULL    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
        if (in_valid_i) begin
          if (command_i == rpia_pkg::CMD_RELEASE) begin
            state_d = S_REL_RD;
          end else if (stat_i.full) begin
            state_d = S_FULL;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_MOD;
      end
      S_MOD: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (stat_i.bit_set) begin
          state_d = S_STEP;
        end else if (slot_free) begin
          cmd_o.map_wr   = 1'b1;
          cmd_o.map_bit  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = rpia_pkg::RES_ALLOC;
          state_d        = S_IDLE;
        end
      end
      S_REL_RD: begin
        cmd_o.rel_rd = 1'b1;
        state_d      = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (slot_free) begin
          cmd_o.map_wr   = stat_i.rel_hit;
          cmd_o.map_bit  = 1'b0;
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = rpia_pkg::RES_RELEASE;
          state_d        = S_IDLE;
        end
      end
      S_FULL: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = rpia_pkg::RES_NONE_FREE;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/rpia_dp.sv -----
// datapath of the random probe id allocator: lfsr, modulo unit, in-use bitmap
// memory, used counter and result register; depends on rpia_pkg
module rpia_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rpia_pkg::LFSR_W-1:0]      cfg_rng_seed_i,
  input  logic [rpia_pkg::ID_W-1:0]        id_i,
  input  rpia_pkg::dp_cmd_t                cmd_i,
  output rpia_pkg::dp_stat_t               stat_o,
  output logic [rpia_pkg::ID_W-1:0]        id_out_o,
  output logic [rpia_pkg::STAT_W-1:0]      status_o
);

  logic [rpia_pkg::LFSR_W-1:0]  lfsr_q, lfsr_next;
  logic [rpia_pkg::PROD1_W-1:0] prod1_q;
  logic [rpia_pkg::PROD2_W-1:0] prod2_q, rem_raw;
  logic [rpia_pkg::Q_W-1:0]     quot;
  logic [rpia_pkg::REM_W-1:0]   rem;
  logic [rpia_pkg::ID_W-1:0]    mod_off, rel_off, rel_off_g, off_q, id_q;
  logic                         in_range;
  logic [rpia_pkg::ROW_W-1:0]   map_mem [rpia_pkg::ROWS];
  logic [rpia_pkg::ROW_W-1:0]   rdata_q, row_mod, wdata;
  logic [rpia_pkg::ROW_AW-1:0]  raddr, waddr, off_row, clr_row_q;
  logic                         rd_en, wr_en, bit_set;
  logic [rpia_pkg::ID_W-1:0]    count_q;
  logic [rpia_pkg::ID_W-1:0]    id_out_q;
  logic [rpia_pkg::STAT_W-1:0]  status_q;

  // probe lfsr
  assign lfsr_next = {1'b0, lfsr_q[rpia_pkg::LFSR_W-1:1]}
                   ^ (lfsr_q[0] ? rpia_pkg::LFSR_TAPS : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= rpia_pkg::LFSR_ONE;
    end else if (cfg_valid_i) begin
      lfsr_q <= (cfg_rng_seed_i == '0) ? rpia_pkg::LFSR_ONE : cfg_rng_seed_i;
    end else if (cmd_i.step) begin
      lfsr_q <= lfsr_next;
    end
  end

  // modulo span: quotient estimate, back multiply, one correction
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      prod1_q <= rpia_pkg::PROD1_W'(lfsr_next) * rpia_pkg::PROD1_W'(rpia_pkg::RECIP);
    end
    if (cmd_i.mul2) begin
      prod2_q <= rpia_pkg::PROD2_W'(quot) * rpia_pkg::PROD2_W'(rpia_pkg::ID_SPAN);
    end
  end

  assign quot    = prod1_q[rpia_pkg::PROD1_W-1 -: rpia_pkg::Q_W];
  assign rem_raw = rpia_pkg::PROD2_W'(lfsr_q) - prod2_q;
  assign rem     = rem_raw[rpia_pkg::REM_W-1:0];
  assign mod_off = (rem >= rpia_pkg::REM_W'(rpia_pkg::ID_SPAN))
                 ? rpia_pkg::ID_W'(rem - rpia_pkg::REM_W'(rpia_pkg::ID_SPAN))
                 : rpia_pkg::ID_W'(rem);

  // release offset and range check
  assign in_range  = (id_q >= rpia_pkg::ID_LOW_V) && (id_q <= rpia_pkg::ID_HIGH_V);
  assign rel_off   = id_q - rpia_pkg::ID_LOW_V;
  assign rel_off_g = in_range ? rel_off : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      id_q <= id_i;
    end
    if (cmd_i.probe_rd) begin
      off_q <= mod_off;
    end else if (cmd_i.rel_rd) begin
      off_q <= rel_off_g;
    end
  end

  // in-use bitmap, one row of bits per word
  assign rd_en   = cmd_i.probe_rd | cmd_i.rel_rd;
  assign raddr   = cmd_i.probe_rd ? rpia_pkg::ROW_AW'(mod_off >> rpia_pkg::ROW_BIT_W)
                                  : rpia_pkg::ROW_AW'(rel_off_g >> rpia_pkg::ROW_BIT_W);
  assign off_row = rpia_pkg::ROW_AW'(off_q >> rpia_pkg::ROW_BIT_W);
  assign bit_set = rdata_q[off_q[rpia_pkg::ROW_BIT_W-1:0]];

  always_comb begin
    row_mod = rdata_q;
    row_mod[off_q[rpia_pkg::ROW_BIT_W-1:0]] = cmd_i.map_bit;
  end

  assign wr_en = cmd_i.clr | cmd_i.map_wr;
  assign waddr = cmd_i.clr ? clr_row_q : off_row;
  assign wdata = cmd_i.clr ? '0 : row_mod;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= map_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
      count_q   <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_row_q <= clr_row_q + 1'b1;
      end
      if (cmd_i.map_wr) begin
        if (cmd_i.map_bit) begin
          count_q <= count_q + 1'b1;
        end else if (count_q != '0) begin
          count_q <= count_q - 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.res_sel)
        rpia_pkg::RES_ALLOC: begin
          id_out_q <= off_q + rpia_pkg::ID_LOW_V;
          status_q <= rpia_pkg::ST_OK;
        end
        rpia_pkg::RES_RELEASE: begin
          id_out_q <= id_q;
          status_q <= (in_range && bit_set) ? rpia_pkg::ST_OK : rpia_pkg::ST_NOT_ALLOC;
        end
        default: begin
          id_out_q <= '0;
          status_q <= rpia_pkg::ST_NONE_FREE;
        end
      endcase
    end
  end

  assign stat_o.clr_done = (clr_row_q == rpia_pkg::ROW_AW'(rpia_pkg::ROWS - 1));
  assign stat_o.full     = (count_q >= rpia_pkg::ID_SPAN_V);
  assign stat_o.bit_set  = bit_set;
  assign stat_o.rel_hit  = in_range && bit_set;

  assign id_out_o = id_out_q;
  assign status_o = status_q;

endmodule

// ----- bench/random_probe_id_allocator_chk.sv -----
`timescale 1ns / 100ps
// checker for the random probe id allocator: watches the seed, request and result
// channels, predicts each grant from its own bitmap and lfsr, compares in order
// depends on rpia_pkg
module random_probe_id_allocator_chk
  import rpia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [15:0]       cfg_rng_seed_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              command_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ID_W-1:0]   id_out_i,
  input  logic [STAT_W-1:0] status_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [15:0] PROBE_TAPS = 16'hB400;
  localparam int unsigned MAX_PROBES = 65535;
  localparam int unsigned ID_SLOTS   = 1 << ID_W;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
  } grant_t;

  bit          id_taken [0:ID_SLOTS-1];
  logic [15:0] probe_state;
  int unsigned taken_count;
  grant_t      expected_grants[$];

  initial fail_count_o = 0;

  task automatic predict_grant(input logic cmd, input logic [ID_W-1:0] rel_id,
                               output grant_t grant);
    logic [15:0] prev;
    int unsigned cand;
    int unsigned probes;
    bit          found;
    grant.id     = '0;
    grant.status = ST_NONE_FREE;
    if (cmd == CMD_ALLOC) begin
      found  = 1'b0;
      probes = 0;
      if (taken_count < ID_SPAN) begin
        while (!found && probes < MAX_PROBES) begin
          prev        = probe_state;
          probe_state = {1'b0, prev[15:1]} ^ (prev[0] ? PROBE_TAPS : 16'h0000);
          cand        = (int'(probe_state) % ID_SPAN) + ID_LOW;
          probes++;
          if (!id_taken[cand]) begin
            id_taken[cand] = 1'b1;
            taken_count++;
            grant.id     = ID_W'(cand);
            grant.status = ST_OK;
            found        = 1'b1;
          end
        end
      end
    end else begin
      grant.id = rel_id;
      if (rel_id >= ID_LOW && rel_id <= ID_HIGH && id_taken[rel_id]) begin
        id_taken[rel_id] = 1'b0;
        if (taken_count > 0) taken_count--;
        grant.status = ST_OK;
      end else begin
        grant.status = ST_NOT_ALLOC;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < ID_SLOTS; i++) id_taken[i] = 1'b0;
      probe_state = 16'h0001;
      taken_count = 0;
      expected_grants.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        probe_state = (cfg_rng_seed_i == 16'h0000) ? 16'h0001 : cfg_rng_seed_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: unexpected result id %0d status %0d", $realtime, id_out_i,
                     status_i);
          end
        end else begin
          want = expected_grants.pop_front();
          if (id_out_i !== want.id || status_i !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch: id %0d (expected %0d), status %0d (expected %0d)",
                       $realtime, id_out_i, want.id, status_i, want.status);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_grant(command_i, id_i, fresh);
        expected_grants.push_back(fresh);
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

// ----- bench/random_probe_id_allocator_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the random probe id allocator: drives seed writes and requests,
// paces the result side, and gives the verdict from random_probe_id_allocator_chk
// depends on rpia_pkg, random_probe_id_allocator and random_probe_id_allocator_chk
module random_probe_id_allocator_tb;
  import rpia_pkg::*;

  localparam int LIMIT       = 3000000;
  localparam int RAND_ITEMS  = 1600;
  localparam int RAND_PHASES = 4;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [15:0]       cfg_rng_seed_i = 16'h0001;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              command_i      = CMD_ALLOC;
  logic [ID_W-1:0]   id_i           = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [ID_W-1:0]   id_out_o;
  logic [STAT_W-1:0] status_o;

  int fail_count;
  int pending;
  int cycles = 0;

  logic            cmd_in_flight[$];
  logic [ID_W-1:0] live_ids[$];
  int req_seen    = 0;
  int grants_seen = 0;
  int alloc_ok    = 0;
  int rel_ok      = 0;
  int rel_refused = 0;
  int none_free   = 0;
  int seeds_set   = 0;
  bit quiet       = 1'b0;

  random_probe_id_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_rng_seed_i (cfg_rng_seed_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .id_i           (id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .id_out_o       (id_out_o),
    .status_o       (status_o)
  );

  random_probe_id_allocator_chk chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_rng_seed_i (cfg_rng_seed_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .id_i           (id_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .id_out_i       (id_out_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[random_probe_id_allocator] ERROR");
    $finish;
  end

  // handshakes seen at the falling edge ahead of the rising edge that takes them
  always @(negedge clk_i) begin
    logic cmd;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i && cmd_in_flight.size() > 0) begin
        cmd = cmd_in_flight.pop_front();
        grants_seen++;
        if (cmd == CMD_ALLOC) begin
          if (status_o == ST_OK) begin
            live_ids.push_back(id_out_o);
            alloc_ok++;
          end else if (status_o == ST_NONE_FREE) begin
            none_free++;
          end
        end else if (status_o == ST_OK) begin
          rel_ok++;
        end else begin
          rel_refused++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        cmd_in_flight.push_back(command_i);
        req_seen++;
      end
    end
  end

  // result side pacing, with long hold-offs while requests keep coming
  initial begin
    int next_hold;
    int burst;
    int gap;
    next_hold = 300;
    @(posedge clk_i);
    forever begin
      if (req_seen >= next_hold) begin
        next_hold = (next_hold < 1000) ? 1100 : 32'h7fffffff;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      burst = $urandom_range(1, 40);
      out_ready_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = $urandom_range(0, 99);
      gap = (gap < 55) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    id_i       <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [15:0] seed);
    settle();
    cfg_valid_i    <= 1'b1;
    cfg_rng_seed_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seeds_set++;
  endtask

  task automatic pick_release(output logic [ID_W-1:0] id);
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 65 && live_ids.size() > 0) begin
      idx = $urandom_range(0, live_ids.size() - 1);
      id  = live_ids[idx];
      live_ids.delete(idx);
    end else if (r < 80) begin
      id = ID_W'($urandom_range(ID_LOW, ID_HIGH));
    end else begin
      case ($urandom_range(0, 5))
        0:       id = '0;
        1:       id = '1;
        2:       id = ID_W'(ID_LOW - 1);
        3:       id = ID_W'(ID_HIGH + 1);
        default: id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      endcase
    end
  endtask

  initial begin
    logic [ID_W-1:0] rel_id;
    logic [15:0]     seed;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // releases of free and out of range ids, then a few grants on the reset seed
    send_request(CMD_RELEASE, '0);
    send_request(CMD_RELEASE, '1);
    send_request(CMD_RELEASE, ID_W'(ID_LOW - 1));
    send_request(CMD_RELEASE, ID_W'(ID_HIGH + 1));
    send_request(CMD_RELEASE, ID_LOW_V);
    send_request(CMD_RELEASE, ID_HIGH_V);
    repeat (6) send_request(CMD_ALLOC, '0);
    settle();
    rel_id = live_ids.pop_front();
    send_request(CMD_RELEASE, rel_id);
    send_request(CMD_RELEASE, rel_id);
    send_request(CMD_RELEASE, live_ids.pop_front());
    write_seed(16'h0000);
    repeat (3) send_request(CMD_ALLOC, '1);
    write_seed(16'hFFFF);
    repeat (3) send_request(CMD_ALLOC, '0);

    // random mix, reseeded between phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       seed = 16'($urandom_range(1, 65535));
        1:       seed = 16'h8000;
        2:       seed = 16'($urandom_range(1, 65535));
        default: seed = 16'h0001;
      endcase
      write_seed(seed);
      for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
        if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 60) begin
          send_request(CMD_ALLOC, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
        end else begin
          pick_release(rel_id);
          send_request(CMD_RELEASE, rel_id);
        end
      end
    end
    quiet = 1'b0;

    // fill the map until it reports none free, then free some and refill
    write_seed(16'($urandom_range(1, 65535)));
    while (none_free < 3) send_request(CMD_ALLOC, '0);
    send_request(CMD_RELEASE, ID_LOW_V);
    send_request(CMD_RELEASE, ID_HIGH_V);
    repeat (120) begin
      if ($urandom_range(0, 9) == 0) begin
        pick_release(rel_id);
      end else begin
        rel_id = ID_W'($urandom_range(ID_LOW, ID_HIGH));
      end
      send_request(CMD_RELEASE, rel_id);
    end
    repeat (80) send_request(CMD_ALLOC, '0);

    settle();
    repeat (20) @(posedge clk_i);
    $display("%0d requests over %0d seeds: %0d ids granted, %0d released, %0d releases refused",
             req_seen, seeds_set, alloc_ok, rel_ok, rel_refused);
    $display("%0d none-free answers, %0d results taken in %0d cycles", none_free, grants_seen,
             cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("[random_probe_id_allocator] OK");
    end else begin
      $display("[random_probe_id_allocator] ERROR");
    end
    $finish;
  end

endmodule
